### rtl/assert_macros.svh
// Assertion macros for the RTL of the colouring block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

### rtl/gmc_pkg.sv
// Package of constants and codes for the graph colouring block.
`timescale 1ns / 1ps

package gmc_pkg;

   localparam int DEFAULT_NUM_VERTICES = 8;
   localparam int MAX_COLORS = 8;
   localparam int ROW_W = 8;
   localparam int INDEX_W = 3;
   localparam int COLOR_W = 4;

   localparam logic [COLOR_W-1:0] NUM_COLORS_RESET = 4'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_SOLVE = 1'b1;

endpackage

### rtl/graph_m_coloring_backtrack.sv
// Graph m-colouring engine: adjacency store, backtracking search and result streaming.
`timescale 1ns / 1ps
//
// Use of the block:
//   req_ channel: one word per item. kind = load writes row_bits into the adjacency
//     row of vertex row_index (rows past the last vertex are dropped); kind = solve
//     starts a depth-first search over colours 1..num_colors, lowest colour first.
//   rsp_ channel: a solve answers with one word per vertex in index order
//     (found = 1, last on the final vertex), or with a single not-found word.
//   csr_ channel: writes num_colors (counts above eight act as eight). Write it only
//     while the block is idle; the port is always ready.
// Loads and solves:
//   A load leaves the sequencer idle, so rows stream in back to back.
//   A solve visits a vertex in S_READ (one adjacency memory read), then S_TRY (one
//   check of every colour against the neighbours at once); once the search ends,
//   the words follow, one word per cycle while rsp_ready is high.
//   The search length is set by the number of visits that backtracking needs.
// Reset and stalls:
//   Reset empties the graph (per-row valid bits), sets num_colors to 3 and idles.
//   req_ready is low while a solve runs or its words stream out; the last word is
//   held in the output register, so the next item is accepted while it waits.
//   A stalled rsp_ready holds the search at the output stage without loss.

module graph_m_coloring_backtrack
   import gmc_pkg::*;
#(
   parameter int NUM_VERTICES = DEFAULT_NUM_VERTICES
) (
   input  logic               clock,
   input  logic               reset,
   // configuration write
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COLOR_W-1:0] csr_wdata,
   // item channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [INDEX_W-1:0] req_row_index,
   input  logic [ROW_W-1:0]   req_row_bits,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [INDEX_W-1:0] rsp_vertex,
   output logic [COLOR_W-1:0] rsp_vertex_color,
   output logic               rsp_last
);

   // Vertex index width and number of stored row bits (rows hold at most eight).
   localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int RW = (NUM_VERTICES < ROW_W) ? NUM_VERTICES : ROW_W;
   localparam logic [VW-1:0] LAST_VERTEX = VW'(NUM_VERTICES - 1);

   // Sequencer codes.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_TRY  = 3'd2;
   localparam logic [2:0] S_OUT  = 3'd3;
   localparam logic [2:0] S_FAIL = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [VW-1:0] vertex_ff, vertex_in;
   logic [COLOR_W-1:0] cand_ff, cand_in;
   logic [COLOR_W-1:0] num_colors_ff;
   logic [COLOR_W-1:0] colors_ff [NUM_VERTICES];
   logic [COLOR_W-1:0] colors_in [NUM_VERTICES];

   // Adjacency memory: one write port for loads, one registered read port for the search.
   logic [RW-1:0] adj_mem [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] adj_valid_ff;
   logic [RW-1:0] adj_rd_ff;
   logic adj_rd_valid_ff;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_fire;
   logic load_we;
   logic [VW-1:0] load_addr;
   logic slot_free;
   logic [COLOR_W-1:0] limit;
   logic [RW-1:0] row;
   logic [MAX_COLORS-1:0] forbid;
   logic [MAX_COLORS-1:0] allowed;
   logic [COLOR_W-1:0] pick;
   logic [VW-1:0] sel_idx;
   logic [COLOR_W-1:0] sel_color;
   logic fail_word_bad;
   logic colour_ok;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;

   // Drop loads whose row lies past the last vertex.
   assign load_we = req_fire && (req_kind == KIND_LOAD)
                    && ({29'd0, req_row_index} < 32'(NUM_VERTICES));
   assign load_addr = VW'(req_row_index);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign limit = (num_colors_ff > COLOR_W'(MAX_COLORS)) ? COLOR_W'(MAX_COLORS)
                                                          : num_colors_ff;

   // One shared colour read: the vertex being streamed, or the previous vertex on backtrack.
   assign sel_idx = (state_ff == S_OUT) ? vertex_ff : vertex_ff - VW'(1);
   assign sel_color = colors_ff[sel_idx];

   assign row = adj_rd_valid_ff ? adj_rd_ff : '0;

   // Colours held by marked neighbours, then the lowest free colour in range.
   always_comb begin
      logic [COLOR_W-1:0] code;
      forbid = '0;
      for (int i = 0; i < RW; i++) begin
         code = colors_ff[i] - COLOR_W'(1);
         if (row[i] && (colors_ff[i] != '0)) begin
            forbid[code[2:0]] = 1'b1;
         end
      end
      for (int k = 0; k < MAX_COLORS; k++) begin
         allowed[k] = !forbid[k] && (COLOR_W'(k + 1) >= cand_ff)
                      && (COLOR_W'(k + 1) <= limit);
      end
      pick = '0;
      for (int k = MAX_COLORS - 1; k >= 0; k--) begin
         if (allowed[k]) begin
            pick = COLOR_W'(k + 1);
         end
      end
   end

   // Search sequencer and result streaming.
   always_comb begin
      state_in = state_ff;
      vertex_in = vertex_ff;
      cand_in = cand_ff;
      colors_in = colors_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Start a solve from an empty colouring.
            if (req_fire && (req_kind == KIND_SOLVE)) begin
               for (int i = 0; i < NUM_VERTICES; i++) begin
                  colors_in[i] = '0;
               end
               vertex_in = '0;
               cand_in = COLOR_W'(1);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_TRY;
         end
         S_TRY: begin
            if (pick != '0) begin
               // Place the colour and advance, or finish on the last vertex.
               colors_in[vertex_ff] = pick;
               if (vertex_ff == LAST_VERTEX) begin
                  vertex_in = '0;
                  state_in = S_OUT;
               end else begin
                  vertex_in = vertex_ff + VW'(1);
                  cand_in = COLOR_W'(1);
                  state_in = S_READ;
               end
            end else if (vertex_ff == '0) begin
               cand_in = '0;
               state_in = S_FAIL;
            end else begin
               // Step back: retry the previous vertex from its next colour.
               vertex_in = sel_idx;
               cand_in = sel_color + COLOR_W'(1);
               colors_in[sel_idx] = '0;
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_vertex_in = INDEX_W'(vertex_ff);
               rsp_color_in = sel_color;
               rsp_last_in = (vertex_ff == LAST_VERTEX);
               if (vertex_ff == LAST_VERTEX) begin
                  state_in = S_IDLE;
               end else begin
                  vertex_in = vertex_ff + VW'(1);
               end
            end
         end
         S_FAIL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_vertex_in = '0;
               rsp_color_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Adjacency memory: write on load, registered read at the current vertex.
   always_ff @(posedge clock) begin
      if (load_we) begin
         adj_mem[load_addr] <= req_row_bits[RW-1:0];
      end
      adj_rd_ff <= adj_mem[vertex_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vertex_ff <= '0;
         cand_ff <= '0;
         num_colors_ff <= NUM_COLORS_RESET;
         adj_valid_ff <= '0;
         adj_rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_VERTICES; i++) begin
            colors_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         vertex_ff <= vertex_in;
         cand_ff <= cand_in;
         colors_ff <= colors_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_rd_valid_ff <= adj_valid_ff[vertex_ff];
         if (load_we) begin
            adj_valid_ff[load_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            num_colors_ff <= csr_wdata;
         end
      end
   end

   // Result payload holds until a new word is loaded.
   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_vertex_color = rsp_color_ff;
   assign rsp_last = rsp_last_ff;

   assign fail_word_bad = rsp_valid && !rsp_found && (!rsp_last || (rsp_vertex_color != '0));
   assign colour_ok = (rsp_vertex_color != '0) && (rsp_vertex_color <= limit);

`include "assert_macros.svh"

   `ASSERT_CLK(a_try_follows_read, (state_ff == S_TRY) |-> $past(state_ff) == S_READ, "no row read")
   `ASSERT_NEVER(a_fail_single_word, fail_word_bad, "bad not-found word")
   `ASSERT_CLK(a_colour_in_range, (rsp_valid && rsp_found) |-> colour_ok, "colour out of range")

endmodule
